@@ rtl/apmq_pkg.sv @@
// Shared types and constants for the alarm priority message queue.
// Used by the queue cells, the output buffer and the top level.
package apmq_pkg;

  localparam int MSG_W   = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_NORMAL = 2'd0,
    OP_ALARM  = 2'd1,
    OP_RECV   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_BUSY  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  typedef struct packed {
    status_t              status;
    logic                 kind;
    logic [MSG_W-1:0]     message;
    logic [COUNT_W-1:0]   count;
    logic                 alarm;
  } res_t;

endpackage

@@ rtl/apmq_cell.sv @@
// One cell of the normal-word queue: a valid bit and one stored word.
// Takes the word from its right neighbor on a pop; depends on apmq_pkg.
module apmq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  apmq_pkg::cell_ctrl_t    ctrl,
  input  logic                    prev_valid,
  input  logic [DATA_WIDTH-1:0]   push_word,
  input  logic                    next_valid,
  input  logic [DATA_WIDTH-1:0]   next_word,
  output logic                    valid,
  output logic [DATA_WIDTH-1:0]   word
);
  import apmq_pkg::*;

  logic load;

  // The first empty cell behind a full one is the tail.
  assign load = ctrl.push && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= next_valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      word <= next_word;
    end else if (load) begin
      word <= push_word;
    end
  end

endmodule

@@ rtl/apmq_out_buf.sv @@
// Two-entry output stage: a result register with a skid register behind it.
// Depends on apmq_pkg for the result word type.
module apmq_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  apmq_pkg::res_t  push_res,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output apmq_pkg::res_t  out_res
);
  import apmq_pkg::*;

  logic skid_valid;
  res_t skid_res;

  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= push_res;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_res <= push_res;
      end
    end else if (push) begin
      skid_res <= push_res;
    end
  end

endmodule

@@ rtl/alarm_priority_message_queue.sv @@
// Alarm priority message queue: one alarm slot beside a row of DEPTH queue cells.
// Result words are registered in the output stage, or its skid register on a stall.
// Throughput: one word per cycle while in_ready holds; no operation is multi-state.
// A two-entry output stage keeps input accepted while one result waits.
// Reset empties all cells, clears the count and the alarm flag, and drops results.
// Depends on apmq_pkg, apmq_cell and apmq_out_buf.
module alarm_priority_message_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     operation,
  input  logic [apmq_pkg::MSG_W-1:0]     message,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic                           received_kind,
  output logic [apmq_pkg::MSG_W-1:0]     received_message,
  output logic [apmq_pkg::COUNT_W-1:0]   normal_count,
  output logic                           alarm_held
);
  import apmq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic                  accept;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  alarm_valid;
  logic                  alarm_valid_next;
  logic [DATA_WIDTH-1:0] alarm_word;
  logic                  alarm_set;
  logic [DATA_WIDTH-1:0] in_word;
  logic [DATA_WIDTH-1:0] got_word;
  logic [DEPTH-1:0]      cell_valid;
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  cell_ctrl_t            ctrl;
  res_t                  res;
  res_t                  out_res;
  status_t               res_status;
  logic                  res_kind;

  logic [DATA_WIDTH+MSG_W-1:0] in_ext;
  logic [DATA_WIDTH+MSG_W-1:0] got_ext;
  logic [CW+COUNT_W-1:0]       count_ext;

  assign accept  = in_valid && in_ready;
  assign in_ext  = {{DATA_WIDTH{1'b0}}, message};
  assign in_word = in_ext[DATA_WIDTH-1:0];

  always_comb begin
    res_status       = ST_DONE;
    res_kind         = 1'b0;
    got_word         = '0;
    ctrl             = '0;
    alarm_set        = 1'b0;
    count_next       = count;
    alarm_valid_next = alarm_valid;
    unique case (op_t'(operation))
      OP_NORMAL: begin
        if (count == FULL_COUNT) begin
          res_status = ST_FULL;
        end else begin
          ctrl.push  = accept;
          count_next = count + 1'b1;
        end
      end
      OP_ALARM: begin
        if (alarm_valid) begin
          res_status = ST_BUSY;
        end else begin
          alarm_set        = accept;
          alarm_valid_next = 1'b1;
        end
      end
      OP_RECV: begin
        if (alarm_valid) begin
          res_kind         = 1'b1;
          got_word         = alarm_word;
          alarm_valid_next = 1'b0;
        end else if (count != '0) begin
          got_word   = cell_word[0];
          ctrl.pop   = accept;
          count_next = count - 1'b1;
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  assign got_ext   = {{MSG_W{1'b0}}, got_word};
  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  always_comb begin
    res.status  = res_status;
    res.kind    = res_kind;
    res.message = got_ext[MSG_W-1:0];
    res.count   = count_ext[COUNT_W-1:0];
    res.alarm   = alarm_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      alarm_valid <= 1'b0;
    end else if (accept) begin
      count       <= count_next;
      alarm_valid <= alarm_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (alarm_set) begin
      alarm_word <= in_word;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_v;
    logic                  next_v;
    logic [DATA_WIDTH-1:0] next_w;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_w = '0;
    end else begin : g_inner
      assign next_v = cell_valid[i+1];
      assign next_w = cell_word[i+1];
    end

    apmq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .push_word  (in_word),
      .next_valid (next_v),
      .next_word  (next_w),
      .valid      (cell_valid[i]),
      .word       (cell_word[i])
    );
  end

  apmq_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_res   (res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign status           = out_res.status;
  assign received_kind    = out_res.kind;
  assign received_message = out_res.message;
  assign normal_count     = out_res.count;
  assign alarm_held       = out_res.alarm;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("normal count exceeds the queue depth");

  a_cells_match_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("occupied cells disagree with the normal count");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (count != '0) == cell_valid[0])
    else $error("head cell empty while words are held");

  a_alarm_first: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_RECV) && alarm_valid |=> !alarm_valid && $stable(count))
    else $error("receive did not take the alarm word first");

  a_no_ready_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !in_ready |=> !in_ready || out_ready)
    else $error("output stage released a stalled skid word");
`endif

endmodule
